@@ hw/rtl/bra_pkg.sv @@
package bra_pkg;

   localparam int MAP_BYTES_DEF = 128;
   localparam int KIND_W        = 3;
   localparam int INDEX_W       = 10;
   localparam int LENGTH_W      = 11;
   localparam int BYTE_W        = 8;
   localparam int BIT_SEL_W     = 3;
   localparam int LOCAL_RUN_W   = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIND  = 3'd0,
      KIND_SET   = 3'd1,
      KIND_CLEAR = 3'd2,
      KIND_TEST  = 3'd3,
      KIND_WIPE  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_FIND_FIRST,
      ST_FIND,
      ST_RMW_READ,
      ST_RMW_UPDATE,
      ST_WIPE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_ready;
      logic load_req;
      logic step;
      logic run_upd;
      logic rd_next;
      logic rd_idx;
      logic wr_zero;
      logic wr_mod;
      logic cap_find;
      logic cap_test;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              req_valid;
      logic [KIND_W-1:0] kind;
      logic              want_bad;
      logic              idx_oob;
      logic              scan_last;
      logic              hit;
      logic              out_stall;
   } status_type;

endpackage

@@ hw/rtl/bra_req_if.sv @@
interface bra_req_if;
   import bra_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [INDEX_W-1:0]  bit_index;
   logic [LENGTH_W-1:0] run_length;

   modport source (output valid, output kind, output bit_index, output run_length,
                   input ready);
   modport sink (input valid, input kind, input bit_index, input run_length,
                 output ready);
endinterface

@@ hw/rtl/bra_rsp_if.sv @@
interface bra_rsp_if;
   import bra_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [INDEX_W-1:0] start_index;
   logic               bit_value;

   modport source (output valid, output found, output start_index, output bit_value,
                   input ready);
   modport sink (input valid, input found, input start_index, input bit_value,
                 output ready);
endinterface

@@ hw/rtl/bra_ram.sv @@
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/bra_ctrl.sv @@
module bra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  bra_pkg::status_type status,
   output bra_pkg::cmd_type    cmd
);
   import bra_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            if (status.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (kind_type'(status.kind))
               KIND_FIND:  state_in = status.want_bad ? ST_FINISH : ST_FIND_FIRST;
               KIND_SET,
               KIND_CLEAR,
               KIND_TEST:  state_in = status.idx_oob ? ST_FINISH : ST_RMW_READ;
               KIND_WIPE:  state_in = ST_WIPE;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_FIND_FIRST: state_in = ST_FIND;
         ST_FIND: begin
            if (status.hit || status.scan_last) state_in = ST_FINISH;
         end
         ST_RMW_READ:   state_in = ST_RMW_UPDATE;
         ST_RMW_UPDATE: state_in = ST_FINISH;
         ST_WIPE: begin
            if (status.scan_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            cmd.wr_zero = 1'b1;
            cmd.step    = 1'b1;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load_req  = status.req_valid;
         end
         ST_DISPATCH, ST_FIND_FIRST: begin
            cmd = '0;
         end
         ST_FIND: begin
            if (status.hit) begin
               cmd.cap_find = 1'b1;
            end else if (!status.scan_last) begin
               cmd.rd_next = 1'b1;
               cmd.step    = 1'b1;
               cmd.run_upd = 1'b1;
            end
         end
         ST_RMW_READ: begin
            cmd.rd_idx = 1'b1;
         end
         ST_RMW_UPDATE: begin
            if (kind_type'(status.kind) == KIND_TEST) begin
               cmd.cap_test = 1'b1;
            end else begin
               cmd.wr_mod = 1'b1;
            end
         end
         ST_WIPE: begin
            cmd.wr_zero = 1'b1;
            cmd.step    = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = !status.out_stall;
         end
         default: cmd = '0;
      endcase
   end
endmodule

@@ hw/rtl/bra_datapath.sv @@
module bra_datapath #(
   parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   bra_req_if.sink             req_ch,
   bra_rsp_if.source           rsp_ch,
   input  bra_pkg::cmd_type    cmd,
   output bra_pkg::status_type status
);
   import bra_pkg::*;

   localparam int MAP_BITS = MAP_BYTES * BYTE_W;
   localparam int ADDR_W   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_RAW  = $clog2(MAP_BITS + 1);
   localparam int CNT_W    = (CNT_RAW > LENGTH_W) ? CNT_RAW : LENGTH_W;
   localparam int POS_W    = ADDR_W + BIT_SEL_W;
   localparam int SUM_W    = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;
   localparam int IB_W     = (ADDR_W > INDEX_W - BIT_SEL_W) ? ADDR_W : INDEX_W - BIT_SEL_W;

   logic [KIND_W-1:0]   kind_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [LENGTH_W-1:0] want_ff;
   logic [ADDR_W-1:0]   scan_addr_ff;
   logic [CNT_W-1:0]    run_ff;
   logic                res_found_ff;
   logic [INDEX_W-1:0]  res_start_ff;
   logic                res_bit_ff;
   logic                out_valid_ff;
   logic                out_found_ff;
   logic [INDEX_W-1:0]  out_start_ff;
   logic                out_bit_ff;

   logic [IB_W-1:0]        idx_byte_wide;
   logic [ADDR_W-1:0]      idx_byte;
   logic [BYTE_W-1:0]      bit_mask;
   logic [BYTE_W-1:0]      rdata;
   logic                   we;
   logic [ADDR_W-1:0]      waddr;
   logic [BYTE_W-1:0]      wdata;
   logic [ADDR_W-1:0]      raddr;
   logic [CNT_W-1:0]       want_ext;
   logic [LOCAL_RUN_W-1:0] local_run;
   logic [CNT_W-1:0]       run_at [BYTE_W];
   logic [BYTE_W-1:0]      hit_at;
   logic [BIT_SEL_W-1:0]   hit_sel;
   logic [SUM_W-1:0]       start_sum;

   assign idx_byte_wide = IB_W'(idx_ff[INDEX_W-1:BIT_SEL_W]);
   assign idx_byte      = idx_byte_wide[ADDR_W-1:0];
   assign bit_mask      = BYTE_W'(1) << idx_ff[BIT_SEL_W-1:0];
   assign want_ext      = CNT_W'(want_ff);

   always_comb begin
      priority if (cmd.rd_next) raddr = scan_addr_ff + ADDR_W'(1);
      else if (cmd.rd_idx)      raddr = idx_byte;
      else                      raddr = scan_addr_ff;
   end

   assign we    = cmd.wr_zero | cmd.wr_mod;
   assign waddr = cmd.wr_zero ? scan_addr_ff : idx_byte;
   always_comb begin
      priority if (cmd.wr_zero)                   wdata = '0;
      else if (kind_type'(kind_ff) == KIND_SET)   wdata = rdata | bit_mask;
      else                                        wdata = rdata & ~bit_mask;
   end

   bra_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Free run ending at each bit of the current byte, carried from earlier bytes when the
   // byte is free up to that bit.
   always_comb begin
      local_run = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         local_run = rdata[i] ? '0 : local_run + LOCAL_RUN_W'(1);
         if (local_run == LOCAL_RUN_W'(i + 1)) begin
            run_at[i] = run_ff + CNT_W'(i + 1);
         end else begin
            run_at[i] = CNT_W'(local_run);
         end
         hit_at[i] = (run_at[i] == want_ext);
      end
   end

   always_comb begin
      hit_sel = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (hit_at[i]) hit_sel = BIT_SEL_W'(i);
      end
   end

   assign start_sum = SUM_W'({scan_addr_ff, hit_sel}) + SUM_W'(1) - SUM_W'(want_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_ch.kind;
         idx_ff  <= req_ch.bit_index;
         want_ff <= req_ch.run_length;
      end
      if (cmd.load_req) begin
         run_ff <= '0;
      end else if (cmd.run_upd) begin
         run_ff <= run_at[BYTE_W-1];
      end
      if (cmd.load_req) begin
         res_found_ff <= 1'b0;
         res_start_ff <= '0;
         res_bit_ff   <= 1'b0;
      end else begin
         if (cmd.cap_find) begin
            res_found_ff <= 1'b1;
            res_start_ff <= start_sum[INDEX_W-1:0];
         end
         if (cmd.cap_test) begin
            res_bit_ff <= rdata[idx_ff[BIT_SEL_W-1:0]];
         end
      end
      if (cmd.load_out) begin
         out_found_ff <= res_found_ff;
         out_start_ff <= res_start_ff;
         out_bit_ff   <= res_bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            scan_addr_ff <= '0;
         end else if (cmd.step) begin
            scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ch.ready       = cmd.req_ready;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.found       = out_found_ff;
   assign rsp_ch.start_index = out_start_ff;
   assign rsp_ch.bit_value   = out_bit_ff;

   assign status.req_valid = req_ch.valid;
   assign status.kind      = kind_ff;
   assign status.want_bad  = (want_ff == '0) || (32'(want_ff) > 32'(MAP_BITS));
   assign status.idx_oob   = 32'(idx_ff) >= 32'(MAP_BITS);
   assign status.scan_last = scan_addr_ff == ADDR_W'(MAP_BYTES - 1);
   assign status.hit       = |hit_at;
   assign status.out_stall = out_valid_ff && !rsp_ch.ready;
endmodule

@@ hw/rtl/bitmap_run_allocator_core.sv @@
// First-fit allocator over a map of used/free bits, MAP_BYTES bytes of eight bits each.
// Requests arrive on the req_ch channel and each gives exactly one transaction on rsp_ch;
// a transaction moves when valid and ready are both high at a rising clock edge.
// A request finds the lowest free run of run_length bits, sets, clears or tests the bit at
// bit_index, or clears the whole map. Requests are handled one at a time.
// Set, clear and test read the addressed byte and then write or sample it; an unused kind
// or a rejected request goes straight to the response, a map clear writes every byte and a
// find reads bytes until a run is found or the last byte is read. The find walks the map
// memory one byte per cycle through its single read port, which sets a find's throughput.
// After reset the block sweeps the map to all free, one byte per cycle, and ready stays
// low during the sweep. A response waits in an output register while the receiver
// stalls; the next request is accepted meanwhile and its result is held back until the
// register has been taken.
module bitmap_run_allocator_core #(
   parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bra_req_if.sink   req_ch,
   bra_rsp_if.source rsp_ch
);
   import bra_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences each request; the datapath owns the map memory, the scan
   // counters and the result and output registers.
   bra_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   bra_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

   // Only one request is in flight: acceptance always drops ready on the next cycle.
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while another one is in flight");

   // A result is never loaded over a response that the receiver has not yet taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("pending response overwritten");

   // A response carries a find result, a test result or neither, never both.
   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.found && rsp_ch.bit_value))
      else $error("response reports both a found run and a used bit");

   // Clearing writes and read-modify-write updates never collide on the write port.
   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_zero && cmd.wr_mod))
      else $error("two map writes requested in one cycle");
endmodule

@@ bench/bitmap_run_allocator_checker.sv @@
module bitmap_run_allocator_checker #(
   parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   bra_req_if   req_mon,
   bra_rsp_if   rsp_mon,
   output int   failures,
   output int   awaited,
   output int   responses_checked,
   output int   runs_found
);
   import bra_pkg::*;

   localparam int MAP_BITS   = MAP_BYTES * BYTE_W;
   // Beyond this many failures the count goes on but nothing more is printed.
   localparam int REPORT_CAP = 100;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] start_index;
      logic               bit_value;
   } alloc_result_type;

   logic [MAP_BITS-1:0] shadow_map;
   alloc_result_type    awaited_results[$];
   alloc_result_type    oldest;

   initial begin
      failures          = 0;
      awaited           = 0;
      responses_checked = 0;
      runs_found        = 0;
      shadow_map        = '0;
   end

   task automatic report_failure(input string msg);
      if (failures < REPORT_CAP) begin
         $display("[%0t] %s", $time, msg);
      end
      failures++;
   endtask

   // Applies one request to the shadow map and returns the response it must give.
   function automatic alloc_result_type predict_allocation(input logic [KIND_W-1:0]   kind,
                                                           input logic [INDEX_W-1:0]  idx,
                                                           input logic [LENGTH_W-1:0] want);
      alloc_result_type res;
      int               run_count;
      int               pos;
      int               hit_at;
      res       = '0;
      run_count = 0;
      hit_at    = -1;
      case (kind)
         KIND_FIND: begin
            if (want != 0 && want <= MAP_BITS) begin
               for (pos = 0; pos < MAP_BITS && hit_at < 0; pos++) begin
                  if (shadow_map[pos]) run_count = 0;
                  else run_count++;
                  if (run_count == want) hit_at = pos + 1 - want;
               end
            end
            if (hit_at >= 0) begin
               res.found       = 1'b1;
               res.start_index = hit_at[INDEX_W-1:0];
            end
         end
         KIND_SET:   if (idx < MAP_BITS) shadow_map[idx] = 1'b1;
         KIND_CLEAR: if (idx < MAP_BITS) shadow_map[idx] = 1'b0;
         KIND_TEST:  if (idx < MAP_BITS) res.bit_value = shadow_map[idx];
         KIND_WIPE:  shadow_map = '0;
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_map = '0;
         awaited_results.delete();
      end else begin
         // A response can never belong to a request taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               report_failure("response transaction arrived with no request awaiting it");
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_mon.found !== oldest.found)
                  report_failure($sformatf("response %0d: found is %0b, expected %0b",
                                           responses_checked, rsp_mon.found, oldest.found));
               if (rsp_mon.start_index !== oldest.start_index)
                  report_failure($sformatf("response %0d: start_index is %0d, expected %0d",
                                           responses_checked, rsp_mon.start_index,
                                           oldest.start_index));
               if (rsp_mon.bit_value !== oldest.bit_value)
                  report_failure($sformatf("response %0d: bit_value is %0b, expected %0b",
                                           responses_checked, rsp_mon.bit_value,
                                           oldest.bit_value));
               if (oldest.found) runs_found++;
               responses_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(predict_allocation(req_mon.kind, req_mon.bit_index,
                                                         req_mon.run_length));
         end
      end
      awaited = awaited_results.size();
   end

endmodule

@@ bench/bitmap_run_allocator_core_test.sv @@
module bitmap_run_allocator_core_test;
   import bra_pkg::*;

   localparam int MAP_BYTES      = MAP_BYTES_DEF;
   localparam int MAP_BITS       = MAP_BYTES * BYTE_W;
   localparam int INDEX_MAX      = (1 << INDEX_W) - 1;
   localparam int LENGTH_MAX     = (1 << LENGTH_W) - 1;
   localparam int ITEM_TARGET    = 1950;
   // The final stretch of requests runs with neither side idling.
   localparam int CALM_ITEMS     = 200;
   // The map is filled completely once, after this many requests.
   localparam int FILL_AFTER     = 450;
   // Longest correct quiet stretch is a full-map find plus a stall and a gap, or the
   // clearing sweep after reset; this leaves a wide margin over either.
   localparam int WATCHDOG_LIMIT = 4000;
   // Kind codes that the block does not define; they must leave the map alone.
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   logic clock;
   logic reset;

   int failures;
   int awaited;
   int responses_checked;
   int runs_found;

   int items_sent;
   int kind_count [0:7];
   bit calm;
   int gap_pct;
   int stall_pct;
   int quiet_cycles;
   // Spans that the stimulus has marked used, so that some frees and tests land on them.
   int span_start[$];
   int span_len[$];

   bra_req_if req_ch ();
   bra_rsp_if rsp_ch ();

   bitmap_run_allocator_core #(
      .MAP_BYTES(MAP_BYTES)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // The checker watches both channels, keeps its own copy of the map and compares every
   // response transaction with what it predicted.
   bitmap_run_allocator_checker #(
      .MAP_BYTES(MAP_BYTES)
   ) allocation_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .failures         (failures),
      .awaited          (awaited),
      .responses_checked(responses_checked),
      .runs_found       (runs_found)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver stalls in bursts. Its odds are changed from time to time by the stimulus,
   // so that stretches with no stalls occur as well.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // The watchdog ends a run in which no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Presents one request, possibly after an idle burst, and returns once it has been
   // accepted. Valid is only ever assigned once per falling edge, so a request that
   // follows directly keeps valid high without a glitch.
   task automatic send(input logic [KIND_W-1:0] op, input int idx, input int len);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 10);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= op;
      req_ch.bit_index  <= idx[INDEX_W-1:0];
      req_ch.run_length <= len[LENGTH_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      kind_count[op]++;
   endtask

   // Sets or clears every bit of a span, one request per bit. The run length field is
   // ignored by these requests, so it carries random bits.
   task automatic mark_span(input logic [KIND_W-1:0] op, input int first, input int count);
      int b;
      for (b = first; b < first + count && b < MAP_BITS; b++) begin
         send(op, b, $urandom_range(0, LENGTH_MAX));
      end
   endtask

   // Run lengths for finds: mostly short, with long runs, the whole map, zero and lengths
   // beyond the map mixed in.
   function automatic int pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 10) return $urandom_range(MAP_BITS + 1, LENGTH_MAX);
      if (r < 14) return $urandom_range(MAP_BITS - 64, MAP_BITS);
      if (r < 30) return $urandom_range(13, 300);
      return $urandom_range(1, 12);
   endfunction

   initial begin
      int  order [MAP_BYTES];
      int  i;
      int  j;
      int  tmp;
      int  r;
      int  first;
      int  count;
      int  hole;
      int  actions;
      bit  map_filled;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_FIND;
      req_ch.bit_index  = '0;
      req_ch.run_length = '0;
      items_sent        = 0;
      quiet_cycles      = 0;
      calm              = 1'b0;
      gap_pct           = 20;
      stall_pct         = 20;
      actions           = 0;
      map_filled        = 1'b0;
      for (i = 0; i < 8; i++) kind_count[i] = 0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part. On the empty map: a zero length, the shortest run, the whole map,
      // one more than the map and the all-ones length.
      send(KIND_FIND, 0, 0);
      send(KIND_FIND, 0, 1);
      send(KIND_FIND, 0, MAP_BITS);
      send(KIND_FIND, 0, MAP_BITS + 1);
      send(KIND_FIND, INDEX_MAX, LENGTH_MAX);
      // Occupy both ends of the map and read them back.
      send(KIND_SET, 0, 0);
      send(KIND_SET, MAP_BITS - 1, 0);
      send(KIND_TEST, 0, 0);
      send(KIND_TEST, MAP_BITS - 1, LENGTH_MAX);
      send(KIND_TEST, MAP_BITS / 2, 0);
      // Runs now start at bit 1, and nothing as long as the map minus one fits.
      send(KIND_FIND, 0, 1);
      send(KIND_FIND, 0, MAP_BITS - 2);
      send(KIND_FIND, 0, MAP_BITS - 1);
      send(KIND_CLEAR, 0, 0);
      send(KIND_FIND, 0, MAP_BITS - 1);
      // A completely used byte: a run of eight still fits before it, a run of nine has to
      // go beyond it.
      mark_span(KIND_SET, BYTE_W, BYTE_W);
      send(KIND_FIND, 0, BYTE_W);
      send(KIND_FIND, 0, BYTE_W + 1);
      // Undefined kinds give an all-zero response and change nothing.
      send(KIND_SPARE_HI, INDEX_MAX, LENGTH_MAX);
      send(KIND_SPARE_LO, 0, 0);
      send(KIND_TEST, BYTE_W, 0);
      // Clearing the map frees the whole of it again.
      send(KIND_WIPE, INDEX_MAX, LENGTH_MAX);
      send(KIND_FIND, 0, MAP_BITS);

      // Random part, built from short allocation-like sequences on a map that slowly
      // fills, with frees, tests, occasional clears of the map and some noise.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
         if (actions % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: begin gap_pct = 0;  stall_pct = 0;  end
               1: begin gap_pct = 10; stall_pct = 15; end
               default: begin gap_pct = 35; stall_pct = 35; end
            endcase
         end
         actions++;

         if (!map_filled && items_sent >= FILL_AFTER) begin
            // Fill the map byte by byte in a shuffled order, looking for runs on the way,
            // until not a single bit is left free.
            map_filled = 1'b1;
            for (i = 0; i < MAP_BYTES; i++) order[i] = i;
            for (i = MAP_BYTES - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (i = 0; i < MAP_BYTES; i++) begin
               mark_span(KIND_SET, order[i] * BYTE_W, BYTE_W);
               if (i % 4 == 3) begin
                  send(KIND_FIND, $urandom_range(0, INDEX_MAX), pick_run_length());
                  send(KIND_TEST, $urandom_range(0, MAP_BITS - 1), pick_run_length());
               end
            end
            // A full map has no run of any length; one freed bit is the only run there is.
            send(KIND_FIND, 0, 1);
            send(KIND_FIND, 0, MAP_BITS);
            send(KIND_TEST, $urandom_range(0, MAP_BITS - 1), 0);
            hole = $urandom_range(0, MAP_BITS - 1);
            send(KIND_CLEAR, hole, 0);
            send(KIND_FIND, 0, 1);
            send(KIND_FIND, 0, 2);
            send(KIND_TEST, hole, 0);
            send(KIND_WIPE, $urandom_range(0, INDEX_MAX), $urandom_range(0, LENGTH_MAX));
            span_start.delete();
            span_len.delete();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               // Mark a span used, mostly low in the map so that finds have to skip it.
               if ($urandom_range(0, 1)) first = $urandom_range(0, MAP_BITS - 1);
               else first = $urandom_range(0, MAP_BITS / 4 - 1);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: count = $urandom_range(1, 6);
                  6, 7: count = $urandom_range(BYTE_W, 3 * BYTE_W);
                  default: begin
                     first = first - first % BYTE_W;
                     count = BYTE_W;
                  end
               endcase
               mark_span(KIND_SET, first, count);
               if (span_start.size() < 64) begin
                  span_start.push_back(first);
                  span_len.push_back(count);
               end
            end else if (r < 42) begin
               // Free a span marked earlier, or a single stray bit.
               if (span_start.size() != 0) begin
                  j = $urandom_range(0, span_start.size() - 1);
                  mark_span(KIND_CLEAR, span_start[j], span_len[j]);
                  span_start.delete(j);
                  span_len.delete(j);
               end else begin
                  send(KIND_CLEAR, $urandom_range(0, INDEX_MAX), $urandom_range(0, LENGTH_MAX));
               end
            end else if (r < 72) begin
               send(KIND_FIND, $urandom_range(0, INDEX_MAX), pick_run_length());
            end else if (r < 84) begin
               if (span_start.size() != 0 && $urandom_range(0, 1)) begin
                  j = $urandom_range(0, span_start.size() - 1);
                  send(KIND_TEST, span_start[j] + $urandom_range(0, span_len[j]),
                       $urandom_range(0, LENGTH_MAX));
               end else begin
                  send(KIND_TEST, $urandom_range(0, INDEX_MAX), $urandom_range(0, LENGTH_MAX));
               end
            end else if (r < 87) begin
               send(KIND_WIPE, $urandom_range(0, INDEX_MAX), $urandom_range(0, LENGTH_MAX));
               span_start.delete();
               span_len.delete();
            end else if (r < 91) begin
               send(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                    $urandom_range(0, INDEX_MAX), $urandom_range(0, LENGTH_MAX));
            end else begin
               // Occupy a whole byte, then look for runs of one byte or one bit more, and test its
               // first bit or the bit just after it.
               first = $urandom_range(0, MAP_BYTES - 1) * BYTE_W;
               mark_span(KIND_SET, first, BYTE_W);
               send(KIND_FIND, $urandom_range(0, INDEX_MAX), BYTE_W + $urandom_range(0, 1));
               send(KIND_TEST, first + BYTE_W * $urandom_range(0, 1), 0);
            end
         end
      end

      // All requests are in: let the last responses drain, then wait on in case something
      // unexpected still comes out.
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (MAP_BYTES + 8) @(negedge clock);

      $display("Checked %0d responses: %0d finds (%0d runs located), %0d sets, %0d clears,",
               responses_checked, kind_count[KIND_FIND], runs_found, kind_count[KIND_SET],
               kind_count[KIND_CLEAR]);
      $display("%0d tests, %0d map clears and %0d undefined kinds, with one full-map pass.",
               kind_count[KIND_TEST], kind_count[KIND_WIPE],
               kind_count[KIND_SPARE_LO] + kind_count[KIND_SPARE_LO + 1] +
               kind_count[KIND_SPARE_HI]);
      if (failures == 0 && awaited == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ bitmap_run_allocator_core.f @@
hw/rtl/bra_pkg.sv
hw/rtl/bra_req_if.sv
hw/rtl/bra_rsp_if.sv
hw/rtl/bra_ram.sv
hw/rtl/bra_ctrl.sv
hw/rtl/bra_datapath.sv
hw/rtl/bitmap_run_allocator_core.sv
bench/bitmap_run_allocator_checker.sv
bench/bitmap_run_allocator_core_test.sv
